// ----- sv/psc_pkg.sv -----
`default_nettype none

package psc_pkg;

  localparam int unsigned DEF_COORD_BITS = 32;
  localparam int unsigned DEF_FRAC_BITS  = 16;
  localparam int unsigned DEF_COUNT_BITS = 16;

  localparam int unsigned CMD_BITS     = 3;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned MAXSEG_BITS  = 16;
  localparam int unsigned FIFO_DEPTH   = 4;

  localparam logic [MAXSEG_BITS-1:0] MAXSEG_RESET = '1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_BEGIN = 3'd0,
    CMD_MOVE  = 3'd1,
    CMD_LINE  = 3'd2,
    CMD_CURVE = 3'd3,
    CMD_CLOSE = 3'd4,
    CMD_RECT  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ORIENT_HORIZ   = 2'd0,
    ORIENT_VERT    = 2'd1,
    ORIENT_NEITHER = 2'd2
  } orient_e;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAT_A    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAT_B    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAT_C    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAT_D    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAT_E    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAT_F    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SNAP_TOL = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SEG  = 3'd7;

  // Queue status seen by both the producer and the consumer side.
  typedef struct packed {
    logic room;
    logic nempty;
  } fifo_st_t;

endpackage

`default_nettype wire

// ----- sv/psc_fifo.sv -----
`default_nettype none

module psc_fifo #(
  parameter int unsigned DATA_BITS = 145
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [DATA_BITS-1:0] push_data_i,
  input  wire logic                 pop_i,
  output logic [DATA_BITS-1:0]      head_o,
  output psc_pkg::fifo_st_t         st_o
);
  import psc_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  logic [DATA_BITS-1:0] mem_q [FIFO_DEPTH];
  logic [AW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [AW:0]          cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o    = mem_q[rd_ptr_q];
  assign st_o.room   = (cnt_q != (AW+1)'(FIFO_DEPTH));
  assign st_o.nempty = (cnt_q != '0);

endmodule

`default_nettype wire

// ----- sv/psc_front.sv -----
`default_nettype none

module psc_front #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [psc_pkg::CMD_BITS-1:0]       cmd_i,
  input  wire logic [COORD_BITS-1:0]              xa_i,
  input  wire logic [COORD_BITS-1:0]              ya_i,
  input  wire logic [COORD_BITS-1:0]              xb_i,
  input  wire logic [COORD_BITS-1:0]              yb_i,
  input  wire logic [psc_pkg::MAXSEG_BITS-1:0]    max_seg_i,
  input  wire psc_pkg::fifo_st_t                  fifo_st_i,
  output logic                                    push_o,
  output logic [4*COORD_BITS+COUNT_BITS:0]        push_data_o
);
  import psc_pkg::*;

  localparam int unsigned W    = COORD_BITS;
  localparam int unsigned CB   = COUNT_BITS;
  localparam int unsigned CMPW = (CB > MAXSEG_BITS) ? CB : MAXSEG_BITS;

  logic [W-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [W-1:0]  move_x_q, move_x_d, move_y_q, move_y_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [1:0]    step_q, step_d;
  logic [W-1:0]  rxa_q, rxa_d, rya_q, rya_d, rxb_q, rxb_d, ryb_q, ryb_d;

  logic          accept;
  logic          seg_go, seg_last, seg_last_f, emit, advance;
  logic [W-1:0]  sx0, sy0, ex, ey;
  logic [CB-1:0] cnt_inc;

  function automatic logic can_emit(input logic [CB-1:0] c, input logic [MAXSEG_BITS-1:0] m);
    return (CMPW'(c) < CMPW'(m)) && (c != '1);
  endfunction

  assign in_stall_o = busy_q || !fifo_st_i.room;
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_inc    = cnt_q + CB'(1);

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    move_x_d = move_x_q;
    move_y_d = move_y_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    step_d   = step_q;
    rxa_d    = rxa_q;
    rya_d    = rya_q;
    rxb_d    = rxb_q;
    ryb_d    = ryb_q;
    seg_go   = 1'b0;
    seg_last = 1'b0;
    sx0      = cur_x_q;
    sy0      = cur_y_q;
    ex       = xa_i;
    ey       = ya_i;

    if (busy_q) begin
      // Remaining three sides of a rectangle, one per cycle while the queue has room.
      seg_go   = 1'b1;
      seg_last = (step_q == 2'd3);
      case (step_q)
        2'd1: begin
          ex = rxb_q;
          ey = ryb_q;
        end
        2'd2: begin
          ex = rxa_q;
          ey = ryb_q;
        end
        default: begin
          ex = rxa_q;
          ey = rya_q;
        end
      endcase
    end else if (accept) begin
      case (cmd_i)
        CMD_BEGIN: begin
          cur_x_d  = '0;
          cur_y_d  = '0;
          move_x_d = '0;
          move_y_d = '0;
          cnt_d    = '0;
        end
        CMD_MOVE: begin
          cur_x_d  = xa_i;
          cur_y_d  = ya_i;
          move_x_d = xa_i;
          move_y_d = ya_i;
        end
        CMD_LINE: begin
          seg_go   = 1'b1;
          seg_last = 1'b1;
        end
        CMD_CURVE: begin
          cur_x_d = xa_i;
          cur_y_d = ya_i;
        end
        CMD_CLOSE: begin
          seg_go   = 1'b1;
          seg_last = 1'b1;
          ex       = move_x_q;
          ey       = move_y_q;
        end
        CMD_RECT: begin
          seg_go   = 1'b1;
          move_x_d = xa_i;
          move_y_d = ya_i;
          sx0      = xa_i;
          sy0      = ya_i;
          ex       = xb_i;
          ey       = ya_i;
          rxa_d    = xa_i;
          rya_d    = ya_i;
          rxb_d    = xb_i;
          ryb_d    = yb_i;
          busy_d   = 1'b1;
          step_d   = 2'd1;
        end
        default: begin
        end
      endcase
    end

    emit    = seg_go && can_emit(cnt_q, max_seg_i);
    advance = !busy_q || !emit || fifo_st_i.room;
    // Once the limit is hit every later side is dropped, so this one ends the item.
    seg_last_f = seg_last || !can_emit(cnt_inc, max_seg_i);

    if (seg_go && advance) begin
      cur_x_d = ex;
      cur_y_d = ey;
      if (emit) begin
        cnt_d = cnt_inc;
      end
      if (busy_q) begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  assign push_o      = emit && advance;
  assign push_data_o = {sx0, sy0, ex, ey, cnt_q, seg_last_f};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      move_x_q <= '0;
      move_y_q <= '0;
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      move_x_q <= move_x_d;
      move_y_q <= move_y_d;
      cnt_q    <= cnt_d;
      busy_q   <= busy_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rxa_q <= rxa_d;
    rya_q <= rya_d;
    rxb_q <= rxb_d;
    ryb_q <= ryb_d;
  end

endmodule

`default_nettype wire

// ----- sv/psc_back.sv -----
`default_nettype none

module psc_back #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [4*COORD_BITS+COUNT_BITS:0] head_i,
  input  wire psc_pkg::fifo_st_t             fifo_st_i,
  output logic                               pop_o,
  input  wire logic [COORD_BITS-1:0]         mat_a_i,
  input  wire logic [COORD_BITS-1:0]         mat_b_i,
  input  wire logic [COORD_BITS-1:0]         mat_c_i,
  input  wire logic [COORD_BITS-1:0]         mat_d_i,
  input  wire logic [COORD_BITS-1:0]         mat_e_i,
  input  wire logic [COORD_BITS-1:0]         mat_f_i,
  input  wire logic [COORD_BITS-2:0]         snap_tol_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [COORD_BITS-1:0]              seg_x0_o,
  output logic [COORD_BITS-1:0]              seg_y0_o,
  output logic [COORD_BITS-1:0]              seg_x1_o,
  output logic [COORD_BITS-1:0]              seg_y1_o,
  output logic [1:0]                         orientation_o,
  output logic [COUNT_BITS-1:0]              seg_index_o,
  output logic                               last_o
);
  import psc_pkg::*;

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned PW = 2 * W;

  // Lanes: 0 start x, 1 start y, 2 end x, 3 end y.
  logic signed [W-1:0] k1 [4];
  logic signed [W-1:0] v1 [4];
  logic signed [W-1:0] k2 [4];
  logic signed [W-1:0] v2 [4];
  logic [W-1:0]        tr [4];

  logic [PW-1:0] p1_d [4];
  logic [PW-1:0] p2_d [4];
  logic [PW-1:0] p1_q [4];
  logic [PW-1:0] p2_q [4];
  logic [PW:0]   sum_d [4];
  logic [PW:0]   sum_q [4];
  logic [W-1:0]  crd_d [4];
  logic [W-1:0]  crd_q [4];

  logic          adv;
  logic          v1_q, v2_q, v3_q, out_vld_q;
  logic [CB-1:0] idx1_q, idx2_q, idx3_q;
  logic          last1_q, last2_q, last3_q;
  logic [W-1:0]  hx0, hy0, hx1, hy1;
  logic [CB-1:0] hidx;
  logic          hlast;
  logic [1:0]    orient_d;

  logic [W-1:0]  x0_q, y0_q, x1_q, y1_q;
  logic [1:0]    orient_q;
  logic [CB-1:0] idx_q;
  logic          last_q;

  function automatic logic [W-1:0] shift_sat(input logic [PW:0] s, input logic [W-1:0] t);
    logic [PW:0]   sh;
    logic [PW+1:0] r;
    sh = $signed(s) >>> FRAC_BITS;
    r  = {sh[PW], sh} + {{(W+2){t[W-1]}}, t};
    if (r[PW+1:W-1] == '0 || r[PW+1:W-1] == '1) begin
      return r[W-1:0];
    end
    return r[PW+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic [W:0] abs_diff(input logic [W-1:0] b, input logic [W-1:0] a);
    logic [W:0] d;
    d = {b[W-1], b} - {a[W-1], a};
    return d[W] ? (~d + (W+1)'(1)) : d;
  endfunction

  assign {hx0, hy0, hx1, hy1, hidx, hlast} = head_i;

  // The whole pipe moves together, held only by a stalled full output register.
  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv && fifo_st_i.nempty;

  always_comb begin
    k1[0] = mat_a_i; v1[0] = hx0; k2[0] = mat_c_i; v2[0] = hy0; tr[0] = mat_e_i;
    k1[1] = mat_b_i; v1[1] = hx0; k2[1] = mat_d_i; v2[1] = hy0; tr[1] = mat_f_i;
    k1[2] = mat_a_i; v1[2] = hx1; k2[2] = mat_c_i; v2[2] = hy1; tr[2] = mat_e_i;
    k1[3] = mat_b_i; v1[3] = hx1; k2[3] = mat_d_i; v2[3] = hy1; tr[3] = mat_f_i;
    for (int n = 0; n < 4; n++) begin
      p1_d[n]  = k1[n] * v1[n];
      p2_d[n]  = k2[n] * v2[n];
      sum_d[n] = {p1_q[n][PW-1], p1_q[n]} + {p2_q[n][PW-1], p2_q[n]};
      crd_d[n] = shift_sat(sum_q[n], tr[n]);
    end
  end

  always_comb begin
    if (abs_diff(crd_q[3], crd_q[1]) <= {2'b00, snap_tol_i}) begin
      orient_d = ORIENT_HORIZ;
    end else if (abs_diff(crd_q[2], crd_q[0]) <= {2'b00, snap_tol_i}) begin
      orient_d = ORIENT_VERT;
    end else begin
      orient_d = ORIENT_NEITHER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= fifo_st_i.nempty;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      out_vld_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q     <= p1_d;
      p2_q     <= p2_d;
      sum_q    <= sum_d;
      crd_q    <= crd_d;
      idx1_q   <= hidx;
      last1_q  <= hlast;
      idx2_q   <= idx1_q;
      last2_q  <= last1_q;
      idx3_q   <= idx2_q;
      last3_q  <= last2_q;
      x0_q     <= crd_q[0];
      y0_q     <= crd_q[1];
      x1_q     <= crd_q[2];
      y1_q     <= crd_q[3];
      orient_q <= orient_d;
      idx_q    <= idx3_q;
      last_q   <= last3_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign seg_x0_o      = x0_q;
  assign seg_y0_o      = y0_q;
  assign seg_x1_o      = x1_q;
  assign seg_y1_o      = y1_q;
  assign orientation_o = orient_q;
  assign seg_index_o   = idx_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ----- sv/path_segment_classifier.sv -----
// Path segment classifier.
// Path commands enter on the input channel (in_valid_i / in_stall_o); every
// straight segment they cause, up to the segment limit, leaves on the output
// channel (out_valid_o / out_stall_i) with both ends mapped through the
// affine matrix, an orientation class, its running index and a flag on the
// last segment of the item. Registers are written on the cfg channel, which
// is always ready. A lineto or closepath item is taken every cycle while the
// queue has room and no rectto is being expanded. A rectto item stalls the
// input until the front has stepped through all four sides, one segment a
// cycle while the four-entry queue has room. Other commands emit nothing.
// The back end is a four-stage pipe (products, sums, shift with translation
// and saturation, classification into the output register). Reset clears
// the current point, the subpath start, the segment count and loads the
// identity matrix. A stalled output freezes the back pipe; the queue then
// fills and the input stalls, with nothing lost.
`default_nettype none

module path_segment_classifier #(
  parameter int unsigned COORD_BITS = psc_pkg::DEF_COORD_BITS,
  parameter int unsigned FRAC_BITS  = psc_pkg::DEF_FRAC_BITS,
  parameter int unsigned COUNT_BITS = psc_pkg::DEF_COUNT_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [psc_pkg::CMD_BITS-1:0]      cmd_i,
  input  wire logic [COORD_BITS-1:0]             xa_i,
  input  wire logic [COORD_BITS-1:0]             ya_i,
  input  wire logic [COORD_BITS-1:0]             xb_i,
  input  wire logic [COORD_BITS-1:0]             yb_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [COORD_BITS-1:0]                  seg_x0_o,
  output logic [COORD_BITS-1:0]                  seg_y0_o,
  output logic [COORD_BITS-1:0]                  seg_x1_o,
  output logic [COORD_BITS-1:0]                  seg_y1_o,
  output logic [1:0]                             orientation_o,
  output logic [COUNT_BITS-1:0]                  seg_index_o,
  output logic                                   last_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [psc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [COORD_BITS-1:0]             cfg_data_i
);
  import psc_pkg::*;

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned EW = 4 * COORD_BITS + COUNT_BITS + 1;

  localparam logic [W-1:0] ONE_RESET = W'(1) << FRAC_BITS;
  localparam logic [W-2:0] TOL_RESET = (W-1)'(3) << FRAC_BITS;

  logic [W-1:0]             mat_a_q, mat_b_q, mat_c_q, mat_d_q, mat_e_q, mat_f_q;
  logic [W-2:0]             snap_tol_q;
  logic [MAXSEG_BITS-1:0]   max_seg_q;

  logic          fifo_push, fifo_pop;
  logic [EW-1:0] fifo_wdata, fifo_head;
  fifo_st_t      fifo_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_a_q    <= ONE_RESET;
      mat_b_q    <= '0;
      mat_c_q    <= '0;
      mat_d_q    <= ONE_RESET;
      mat_e_q    <= '0;
      mat_f_q    <= '0;
      snap_tol_q <= TOL_RESET;
      max_seg_q  <= MAXSEG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MAT_A:    mat_a_q    <= cfg_data_i;
        REG_MAT_B:    mat_b_q    <= cfg_data_i;
        REG_MAT_C:    mat_c_q    <= cfg_data_i;
        REG_MAT_D:    mat_d_q    <= cfg_data_i;
        REG_MAT_E:    mat_e_q    <= cfg_data_i;
        REG_MAT_F:    mat_f_q    <= cfg_data_i;
        REG_SNAP_TOL: snap_tol_q <= cfg_data_i[W-2:0];
        REG_MAX_SEG:  max_seg_q  <= cfg_data_i[MAXSEG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  psc_front #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .xa_i        (xa_i),
    .ya_i        (ya_i),
    .xb_i        (xb_i),
    .yb_i        (yb_i),
    .max_seg_i   (max_seg_q),
    .fifo_st_i   (fifo_st),
    .push_o      (fifo_push),
    .push_data_o (fifo_wdata)
  );

  psc_fifo #(
    .DATA_BITS (EW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (fifo_wdata),
    .pop_i       (fifo_pop),
    .head_o      (fifo_head),
    .st_o        (fifo_st)
  );

  psc_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (fifo_head),
    .fifo_st_i     (fifo_st),
    .pop_o         (fifo_pop),
    .mat_a_i       (mat_a_q),
    .mat_b_i       (mat_b_q),
    .mat_c_i       (mat_c_q),
    .mat_d_i       (mat_d_q),
    .mat_e_i       (mat_e_q),
    .mat_f_i       (mat_f_q),
    .snap_tol_i    (snap_tol_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .seg_x0_o      (seg_x0_o),
    .seg_y0_o      (seg_y0_o),
    .seg_x1_o      (seg_x1_o),
    .seg_y1_o      (seg_y1_o),
    .orientation_o (orientation_o),
    .seg_index_o   (seg_index_o),
    .last_o        (last_o)
  );

  // The front never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> fifo_st.room)
    else $error("segment queue overflow");

  // The back never reads an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> fifo_st.nempty)
    else $error("segment queue underflow");

  // A rectangle holds the input while its remaining sides are emitted.
  a_rect_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i == CMD_RECT) |=> in_stall_o)
    else $error("input taken during rectangle expansion");

endmodule

`default_nettype wire

// ----- sim/path_segment_classifier_tb.sv -----
`timescale 1ns / 1ps

module path_segment_classifier_tb;
  import psc_pkg::*;

  localparam int CW = DEF_COORD_BITS;
  localparam int FW = DEF_FRAC_BITS;
  localparam int KW = DEF_COUNT_BITS;
  localparam int LAT_PAD = 12;
  localparam int HANG_LIMIT = 5000;
  localparam int DIR_ROWS = 16;

  // Command codes the block must ignore.
  localparam logic [CMD_BITS-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

  typedef struct {
    logic [CW-1:0] x0, y0, x1, y1;
    orient_e       orient;
    logic [KW-1:0] idx;
    logic          last;
  } seg_t;

  typedef struct {
    logic [CMD_BITS-1:0] op;
    logic [CW-1:0]       xa, ya, xb, yb;
    bit                  known;
    seg_t                want;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [CMD_BITS-1:0] cmd_i;
  logic [CW-1:0] xa_i, ya_i, xb_i, yb_i;
  logic out_valid_o, out_stall_i;
  logic [CW-1:0] seg_x0_o, seg_y0_o, seg_x1_o, seg_y1_o;
  logic [1:0] orientation_o;
  logic [KW-1:0] seg_index_o;
  logic last_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [CW-1:0] cfg_data_i;

  path_segment_classifier dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .cmd_i, .xa_i, .ya_i, .xb_i, .yb_i,
    .out_valid_o, .out_stall_i, .seg_x0_o, .seg_y0_o, .seg_x1_o, .seg_y1_o,
    .orientation_o, .seg_index_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Shadow of the block: matrix, tolerance, limit and path state.
  logic signed [CW-1:0] k_a = 32'h0001_0000, k_b = '0, k_c = '0;
  logic signed [CW-1:0] k_d = 32'h0001_0000, k_e = '0, k_f = '0;
  logic [CW-2:0] tol = 31'd196608;
  logic [MAXSEG_BITS-1:0] seg_limit = MAXSEG_RESET;
  logic [CW-1:0] pt_x = '0, pt_y = '0, sub_x = '0, sub_y = '0;
  logic [KW-1:0] seg_cnt = '0;

  seg_t seg_expect_q[$];
  bit   row_known;
  seg_t row_want;
  row_t dir_tab[DIR_ROWS];

  logic [CW-1:0] gen_x, gen_y, gen_sx, gen_sy;
  bit idle_on, stall_on;
  int stall_left;
  int fail_cnt, items_done, segs_checked, regs_written, quiet;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int span(bit en);
    int r;
    r = $urandom_range(0, 99);
    if (!en || r < 60) span = 0;
    else if (r < 90) span = $urandom_range(1, 3);
    else span = $urandom_range(4, 24);
  endfunction

  // Exact sum of products, floor shift, translation, then saturation.
  function automatic logic [CW-1:0] map_coord(logic signed [CW-1:0] k1, logic signed [CW-1:0] v1,
                                              logic signed [CW-1:0] k2, logic signed [CW-1:0] v2,
                                              logic signed [CW-1:0] t);
    logic signed [127:0] w1, w2, w3, w4, wt, acc;
    w1 = k1; w2 = v1; w3 = k2; w4 = v2; wt = t;
    acc = ((w1 * w2 + w3 * w4) >>> FW) + wt;
    if (acc > SAT_HI) map_coord = 32'h7FFF_FFFF;
    else if (acc < SAT_LO) map_coord = 32'h8000_0000;
    else map_coord = acc[CW-1:0];
  endfunction

  function automatic seg_t mk_seg(logic [CW-1:0] x0, logic [CW-1:0] y0, logic [CW-1:0] x1,
                                  logic [CW-1:0] y1, orient_e o, logic [KW-1:0] idx);
    mk_seg.x0 = x0; mk_seg.y0 = y0; mk_seg.x1 = x1; mk_seg.y1 = y1;
    mk_seg.orient = o; mk_seg.idx = idx; mk_seg.last = 1'b1;
  endfunction

  function automatic row_t mk_row(logic [CMD_BITS-1:0] op, logic [CW-1:0] xa, logic [CW-1:0] ya,
                                  logic [CW-1:0] xb, logic [CW-1:0] yb, bit known, seg_t want);
    mk_row.op = op; mk_row.xa = xa; mk_row.ya = ya; mk_row.xb = xb; mk_row.yb = yb;
    mk_row.known = known; mk_row.want = want;
  endfunction

  task automatic trace_to(logic [CW-1:0] tx, logic [CW-1:0] ty);
    seg_t s;
    longint ex0, ey0, ex1, ey1, dx, dy, tl;
    if (seg_cnt < seg_limit) begin
      s.x0 = map_coord(k_a, pt_x, k_c, pt_y, k_e);
      s.y0 = map_coord(k_b, pt_x, k_d, pt_y, k_f);
      s.x1 = map_coord(k_a, tx, k_c, ty, k_e);
      s.y1 = map_coord(k_b, tx, k_d, ty, k_f);
      ex0 = $signed(s.x0); ey0 = $signed(s.y0);
      ex1 = $signed(s.x1); ey1 = $signed(s.y1);
      dx = ex1 - ex0; dy = ey1 - ey0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      tl = tol;
      if (dy <= tl) s.orient = ORIENT_HORIZ;
      else if (dx <= tl) s.orient = ORIENT_VERT;
      else s.orient = ORIENT_NEITHER;
      s.idx = seg_cnt;
      s.last = 1'b0;
      seg_expect_q.push_back(s);
      seg_cnt = seg_cnt + 1'b1;
    end
    pt_x = tx;
    pt_y = ty;
  endtask

  task automatic predict_item();
    int n0;
    seg_t s;
    n0 = seg_expect_q.size();
    case (cmd_i)
      CMD_BEGIN: begin
        pt_x = '0; pt_y = '0; sub_x = '0; sub_y = '0; seg_cnt = '0;
      end
      CMD_MOVE: begin
        pt_x = xa_i; pt_y = ya_i; sub_x = xa_i; sub_y = ya_i;
      end
      CMD_LINE: trace_to(xa_i, ya_i);
      CMD_CURVE: begin
        pt_x = xa_i; pt_y = ya_i;
      end
      CMD_CLOSE: trace_to(sub_x, sub_y);
      CMD_RECT: begin
        pt_x = xa_i; pt_y = ya_i; sub_x = xa_i; sub_y = ya_i;
        trace_to(xb_i, ya_i);
        trace_to(xb_i, yb_i);
        trace_to(xa_i, yb_i);
        trace_to(xa_i, ya_i);
      end
      default: ;
    endcase
    if (seg_expect_q.size() > n0) begin
      s = seg_expect_q.pop_back();
      s.last = 1'b1;
      // Directed rows with a hand-written answer replace the computed one.
      seg_expect_q.push_back(row_known ? row_want : s);
    end
    items_done++;
  endtask

  task automatic load_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] val);
    case (idx)
      REG_MAT_A:    k_a = val;
      REG_MAT_B:    k_b = val;
      REG_MAT_C:    k_c = val;
      REG_MAT_D:    k_d = val;
      REG_MAT_E:    k_e = val;
      REG_MAT_F:    k_f = val;
      REG_SNAP_TOL: tol = val[CW-2:0];
      REG_MAX_SEG:  seg_limit = val[MAXSEG_BITS-1:0];
      default: ;
    endcase
    regs_written++;
  endtask

  task automatic cmp_field(string tag, logic [CW-1:0] want_v, logic [CW-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, tag, want_v, got_v);
      fail_cnt++;
    end
  endtask

  task automatic check_segment();
    seg_t e;
    if (seg_expect_q.size() == 0) begin
      $display("%0t ns: unexpected segment, expected none, actual idx %h", $time, seg_index_o);
      fail_cnt++;
    end else begin
      e = seg_expect_q.pop_front();
      cmp_field("seg_x0", e.x0, seg_x0_o);
      cmp_field("seg_y0", e.y0, seg_y0_o);
      cmp_field("seg_x1", e.x1, seg_x1_o);
      cmp_field("seg_y1", e.y1, seg_y1_o);
      cmp_field("orientation", e.orient, orientation_o);
      cmp_field("seg_index", e.idx, seg_index_o);
      cmp_field("last", e.last, last_o);
      segs_checked++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_segment();
      if (cfg_valid_i && cfg_ready_o) load_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) predict_item();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet = 0;
    else quiet++;
    if (quiet >= HANG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", quiet);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!stall_on) out_stall_i <= 1'b0;
    else if (stall_left > 0) stall_left <= stall_left - 1;
    else begin
      out_stall_i <= ~out_stall_i;
      stall_left <= span(1'b1);
    end
  end

  task automatic push_cmd(logic [CMD_BITS-1:0] op, logic [CW-1:0] a, logic [CW-1:0] b,
                          logic [CW-1:0] c, logic [CW-1:0] d, bit known, seg_t want);
    int gap;
    gap = span(idle_on);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= op;
    xa_i <= a; ya_i <= b; xb_i <= c; yb_i <= d;
    row_known <= known;
    row_want <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setup(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c,
                             logic [CW-1:0] d, logic [CW-1:0] e, logic [CW-1:0] f,
                             logic [CW-1:0] snap, logic [CW-1:0] maxs);
    write_reg(REG_MAT_A, a);
    write_reg(REG_MAT_B, b);
    write_reg(REG_MAT_C, c);
    write_reg(REG_MAT_D, d);
    write_reg(REG_MAT_E, e);
    write_reg(REG_MAT_F, f);
    write_reg(REG_SNAP_TOL, snap);
    write_reg(REG_MAX_SEG, maxs);
  endtask

  // Drain all segments, then give items that emitted nothing time to clear the pipe.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    row_known <= 1'b0;
    while (seg_expect_q.size() != 0) @(posedge clk_i);
    repeat (LAT_PAD) @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: case ($urandom_range(0, 3))
           0: rand_coord = 32'h7FFF_FFFF;
           1: rand_coord = 32'h8000_0000;
           2: rand_coord = 32'h0000_0000;
           default: rand_coord = 32'hFFFF_FFFF;
         endcase
      1, 2, 3: rand_coord = $urandom;
      default: rand_coord = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [CW-1:0] near_delta();
    near_delta = $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
  endfunction

  function automatic logic [CW-1:0] mod_coef();
    mod_coef = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
  endfunction

  task automatic run_random(int count);
    int done, r;
    logic [CMD_BITS-1:0] op;
    logic [CW-1:0] xa, ya, xb, yb;
    seg_t blank;
    done = 0;
    blank = mk_seg('0, '0, '0, '0, ORIENT_HORIZ, '0);
    while (done < count) begin
      r = $urandom_range(0, 99);
      xa = rand_coord(); ya = rand_coord(); xb = rand_coord(); yb = rand_coord();
      if (r < 4) op = CMD_BEGIN;
      else if (r < 14) op = CMD_MOVE;
      else if (r < 52) begin
        op = CMD_LINE;
        // Many lines stay close to an axis to exercise the snap tolerance.
        if (r < 30) ya = gen_y + near_delta();
        else if (r < 40) xa = gen_x + near_delta();
      end
      else if (r < 60) op = CMD_CURVE;
      else if (r < 72) op = CMD_CLOSE;
      else if (r < 94) op = CMD_RECT;
      else if (r < 97) op = CMD_SPARE_6;
      else op = CMD_SPARE_7;
      push_cmd(op, xa, ya, xb, yb, 1'b0, blank);
      case (op)
        CMD_BEGIN: begin
          gen_x = '0; gen_y = '0; gen_sx = '0; gen_sy = '0;
        end
        CMD_MOVE, CMD_RECT: begin
          gen_x = xa; gen_y = ya; gen_sx = xa; gen_sy = ya;
        end
        CMD_LINE, CMD_CURVE: begin
          gen_x = xa; gen_y = ya;
        end
        CMD_CLOSE: begin
          gen_x = gen_sx; gen_y = gen_sy;
        end
        default: ;
      endcase
      if (op != CMD_SPARE_6 && op != CMD_SPARE_7) done++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = '0;
    xa_i = '0; ya_i = '0; xb_i = '0; yb_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    row_known = 1'b0;
    stall_left = 0;
    fail_cnt = 0; items_done = 0; segs_checked = 0; regs_written = 0; quiet = 0;
    idle_on = 1'b1;
    stall_on = 1'b1;

    // Identity matrix and a tolerance of 3.0 make these answers readable directly.
    dir_tab[0] = mk_row(CMD_LINE, 32'h0005_0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      mk_seg(32'h0, 32'h0, 32'h0005_0000, 32'h0, ORIENT_HORIZ, 16'd0));
    dir_tab[1] = mk_row(CMD_LINE, 32'h0005_0000, 32'h0010_0000, 32'h0, 32'h0, 1'b1,
      mk_seg(32'h0005_0000, 32'h0, 32'h0005_0000, 32'h0010_0000, ORIENT_VERT, 16'd1));
    dir_tab[2] = mk_row(CMD_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hA5A5_5A5A,
      32'h5A5A_A5A5, 1'b0, dir_tab[0].want);
    dir_tab[3] = mk_row(CMD_LINE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1,
      mk_seg(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, ORIENT_NEITHER,
             16'd2));
    dir_tab[4] = mk_row(CMD_CLOSE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1,
      mk_seg(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, ORIENT_NEITHER,
             16'd3));
    dir_tab[5] = mk_row(CMD_CURVE, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 1'b0, dir_tab[0].want);
    // A zero-length segment classes horizontal.
    dir_tab[6] = mk_row(CMD_LINE, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b1,
      mk_seg(32'h0003_0000, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000, ORIENT_HORIZ,
             16'd4));
    // Both deltas exactly at the tolerance, then dy one step above it.
    dir_tab[7] = mk_row(CMD_LINE, 32'h0006_0000, 32'h0004_0000, 32'h0, 32'h0, 1'b1,
      mk_seg(32'h0003_0000, 32'h0001_0000, 32'h0006_0000, 32'h0004_0000, ORIENT_HORIZ,
             16'd5));
    dir_tab[8] = mk_row(CMD_LINE, 32'h0009_0000, 32'h0007_0001, 32'h0, 32'h0, 1'b1,
      mk_seg(32'h0006_0000, 32'h0004_0000, 32'h0009_0000, 32'h0007_0001, ORIENT_VERT,
             16'd6));
    dir_tab[9] = mk_row(CMD_RECT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
      32'h0005_0000, 1'b0, dir_tab[0].want);
    dir_tab[10] = mk_row(CMD_CLOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1,
      mk_seg(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, ORIENT_HORIZ,
             16'd11));
    dir_tab[11] = mk_row(CMD_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 1'b0, dir_tab[0].want);
    dir_tab[12] = mk_row(CMD_SPARE_7, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, dir_tab[0].want);
    dir_tab[13] = mk_row(CMD_BEGIN, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_F0F0,
      32'hF0F0_0F0F, 1'b0, dir_tab[0].want);
    dir_tab[14] = mk_row(CMD_LINE, 32'hFFFF_0000, 32'h0000_0001, 32'h0, 32'h0, 1'b1,
      mk_seg(32'h0, 32'h0, 32'hFFFF_0000, 32'h0000_0001, ORIENT_HORIZ, 16'd0));
    dir_tab[15] = mk_row(CMD_RECT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h8000_0000, 1'b0, dir_tab[0].want);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      push_cmd(dir_tab[i].op, dir_tab[i].xa, dir_tab[i].ya, dir_tab[i].xb, dir_tab[i].yb,
               dir_tab[i].known, dir_tab[i].want);
    settle();
    gen_x = 32'h8000_0000; gen_y = 32'h7FFF_FFFF;
    gen_sx = 32'h8000_0000; gen_sy = 32'h7FFF_FFFF;

    // Fully random coefficients saturate often.
    apply_setup($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, 32'h0010_0000), $urandom);
    run_random(20);
    settle();

    // Extreme coefficients with back-to-back traffic and no output stalls.
    idle_on = 1'b0;
    stall_on = 1'b0;
    apply_setup(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(20);
    settle();

    // Zero matrix and tolerance, with a limit of five segments per path.
    idle_on = 1'b1;
    stall_on = 1'b1;
    apply_setup(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_0005);
    run_random(20);
    settle();

    // A limit of zero drops every segment.
    apply_setup(mod_coef(), mod_coef(), mod_coef(), mod_coef(), $urandom, $urandom,
                32'h0003_0000, 32'h0);
    run_random(10);
    settle();

    apply_setup(mod_coef(), mod_coef(), mod_coef(), mod_coef(),
                $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000,
                $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000,
                $urandom_range(0, 32'h0008_0000), $urandom_range(3, 40));
    run_random(30);
    settle();

    $display("Sent %0d path items and %0d register writes; checked %0d segments.",
             items_done, regs_written, segs_checked);
    $display("Setups: identity, random, extreme, zero with limit five, limit zero, moderate.");
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
